### hw/rtl/byte_mix_hash_64_defines.svh
// Assertion macros shared by the byte_mix_hash_64 RTL.
`ifndef BYTE_MIX_HASH_64_DEFINES_SVH
`define BYTE_MIX_HASH_64_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BMH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("byte_mix_hash_64: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BMH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("byte_mix_hash_64: next-cycle check failed");

`endif

### hw/rtl/bmh_pkg.sv
// Types and constants for the byte_mix_hash_64 block.
package bmh_pkg;

  localparam int ByteW    = 8;
  localparam int NumBytes = 8;
  localparam int StateW   = ByteW * NumBytes;
  localparam int SeedW    = 32;
  localparam int PosW     = $clog2(NumBytes);

  typedef enum logic [0:0] {
    CFG_SEED_FIRST  = 1'b0,
    CFG_SEED_SECOND = 1'b1
  } cfg_index_t;

  // Result of one accepted item, handed from the core to the output register.
  typedef struct packed {
    logic              emit;
    logic [StateW-1:0] digest;
  } core_result_t;

endpackage

### hw/rtl/bmh_channels.sv
// Valid/ready channel interfaces for message bytes and digests.
interface bmh_in_if;
  logic                      valid;
  logic                      ready;
  logic [bmh_pkg::ByteW-1:0] data_byte;
  logic                      has_byte;
  logic                      last;

  modport source (output valid, output data_byte, output has_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input has_byte, input last, output ready);
endinterface

interface bmh_out_if;
  logic                       valid;
  logic                       ready;
  logic [bmh_pkg::StateW-1:0] digest;

  modport source (output valid, output digest, input ready);
  modport sink   (input valid, input digest, output ready);
endinterface

### hw/rtl/byte_mix_hash_64.sv
// Top level of the 64-bit byte-stream hash: seed registers and digest output register.
//
//   Channel   Direction  Payload                        Transfer when
//   in_if     sink       data_byte[7:0] has_byte last   in_if.valid && in_if.ready
//   out_if    source     digest[63:0]                   out_if.valid && out_if.ready
//   cfg_*     write      cfg_index, cfg_wdata[31:0]     cfg_we
//
// One item is accepted per cycle while in_if.ready is high; the digest of a last item appears in the next cycle.
// The byte XOR and the scramble of the 64-bit state are done in the same cycle.
// Synchronous reset clears the seeds, the message state and the output valid.
// in_if.ready drops only while a digest waits in the output register and
// out_if.ready is low.
`include "byte_mix_hash_64_defines.svh"

module byte_mix_hash_64 (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  bmh_pkg::cfg_index_t           cfg_index,
  input  logic [bmh_pkg::SeedW-1:0]     cfg_wdata,
  bmh_in_if.sink                        in_if,
  bmh_out_if.source                     out_if
);

  logic [bmh_pkg::SeedW-1:0]  seed_first_r;
  logic [bmh_pkg::SeedW-1:0]  seed_second_r;
  logic [bmh_pkg::StateW-1:0] seed_state;
  logic                       out_valid_r, out_valid_nxt;
  logic [bmh_pkg::StateW-1:0] out_digest_r;
  logic                       in_xfer;
  bmh_pkg::core_result_t      core_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_first_r  <= '0;
      seed_second_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bmh_pkg::CFG_SEED_FIRST:  seed_first_r  <= cfg_wdata;
        bmh_pkg::CFG_SEED_SECOND: seed_second_r <= cfg_wdata;
      endcase
    end
  end

  bmh_seed_pack u_seed_pack (
    .seed_first   (seed_first_r),
    .seed_second  (seed_second_r),
    .packed_state (seed_state)
  );

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_xfer     = in_if.valid && in_if.ready;

  bmh_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (in_xfer),
    .data_byte  (in_if.data_byte),
    .has_byte   (in_if.has_byte),
    .last       (in_if.last),
    .seed_state (seed_state),
    .result     (core_res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (core_res.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (core_res.emit) begin
      out_digest_r <= core_res.digest;
    end
  end

  assign out_if.valid  = out_valid_r;
  assign out_if.digest = out_digest_r;

  `BMH_ASSERT_NEXT(a_last_gives_digest, clk, rst_n, in_xfer && in_if.last, out_valid_r)
  `BMH_ASSERT_NEXT(a_no_spurious_digest, clk, rst_n,
                   !(in_xfer && in_if.last) && (!out_valid_r || out_if.ready), !out_valid_r)
  `BMH_ASSERT_NOW(a_emit_only_when_free, clk, rst_n, core_res.emit,
                  !out_valid_r || out_if.ready)

endmodule

### hw/rtl/bmh_seed_pack.sv
// Packs the two seeds into the initial hash state.
module bmh_seed_pack (
  input  logic [bmh_pkg::SeedW-1:0]  seed_first,
  input  logic [bmh_pkg::SeedW-1:0]  seed_second,
  output logic [bmh_pkg::StateW-1:0] packed_state
);

  logic [1:0] extra_bytes;
  logic [5:0] shift_amt;

  // The first seed always takes at least one byte; leading zero bytes are dropped.
  always_comb begin
    if (seed_first[31:24] != 8'd0) begin
      extra_bytes = 2'd3;
    end else if (seed_first[23:16] != 8'd0) begin
      extra_bytes = 2'd2;
    end else if (seed_first[15:8] != 8'd0) begin
      extra_bytes = 2'd1;
    end else begin
      extra_bytes = 2'd0;
    end
  end

  assign shift_amt    = {3'({1'b0, extra_bytes} + 3'd1), 3'b000};
  assign packed_state = bmh_pkg::StateW'(seed_first)
                      | (bmh_pkg::StateW'(seed_second) << shift_amt);

endmodule

### hw/rtl/bmh_mix.sv
// Byte scramble applied after each full block and at a partial final block.
module bmh_mix (
  input  logic [bmh_pkg::StateW-1:0] state_in,
  output logic [bmh_pkg::StateW-1:0] state_out
);

  logic [bmh_pkg::ByteW-1:0] b [bmh_pkg::NumBytes];

  always_comb begin
    for (int k = 0; k < bmh_pkg::NumBytes; k++) begin
      b[k] = state_in[k*bmh_pkg::ByteW +: bmh_pkg::ByteW];
    end
  end

  // Every output byte is built from the old bytes only.
  assign state_out = {
    8'(b[2] + b[1]),
    8'(b[0] + b[7]),
    ~8'(b[6] + b[1]),
    8'(b[6] + b[3]),
    8'(b[5] + b[0]),
    ~8'(b[2] + b[4]),
    8'(b[5] + b[3]),
    8'(b[7] + b[4])
  };

endmodule

### hw/rtl/bmh_core.sv
// Hash state, byte position and message tracking, one item per cycle while step is high.
`include "byte_mix_hash_64_defines.svh"

module bmh_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [bmh_pkg::ByteW-1:0]   data_byte,
  input  logic                        has_byte,
  input  logic                        last,
  input  logic [bmh_pkg::StateW-1:0]  seed_state,
  output bmh_pkg::core_result_t       result
);

  logic [bmh_pkg::StateW-1:0] state_r, state_nxt;
  logic [bmh_pkg::PosW-1:0]   pos_r, pos_nxt;
  logic                       in_msg_r, in_msg_nxt;

  logic [bmh_pkg::StateW-1:0] base_state;
  logic [bmh_pkg::PosW-1:0]   base_pos;
  logic [bmh_pkg::PosW-1:0]   new_pos;
  logic [bmh_pkg::StateW-1:0] xored_state;
  logic [bmh_pkg::StateW-1:0] mixed_state;
  logic                       do_mix;

  // A new message starts from the packed seeds at position zero.
  assign base_state = in_msg_r ? state_r : seed_state;
  assign base_pos   = in_msg_r ? pos_r : '0;

  always_comb begin
    for (int k = 0; k < bmh_pkg::NumBytes; k++) begin
      xored_state[k*bmh_pkg::ByteW +: bmh_pkg::ByteW] =
        base_state[k*bmh_pkg::ByteW +: bmh_pkg::ByteW]
        ^ ((has_byte && (base_pos == bmh_pkg::PosW'(k))) ? data_byte : '0);
    end
  end

  assign new_pos = has_byte ? bmh_pkg::PosW'(base_pos + 1'b1) : base_pos;

  // A full block and a partial final block never both occur on one item.
  assign do_mix = (has_byte && (new_pos == '0)) || (last && (new_pos != '0));

  bmh_mix u_mix (
    .state_in  (xored_state),
    .state_out (mixed_state)
  );

  assign state_nxt  = do_mix ? mixed_state : xored_state;
  assign pos_nxt    = last ? '0 : new_pos;
  assign in_msg_nxt = !last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      in_msg_r <= 1'b0;
    end else if (step) begin
      pos_r    <= pos_nxt;
      in_msg_r <= in_msg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      state_r <= state_nxt;
    end
  end

  assign result.emit   = step && last;
  assign result.digest = state_nxt;

  `BMH_ASSERT_NEXT(a_last_closes_msg, clk, rst_n, step && last, !in_msg_r && (pos_r == '0))
  `BMH_ASSERT_NEXT(a_item_opens_msg, clk, rst_n, step && !last, in_msg_r)
  `BMH_ASSERT_NOW(a_pos_zero_when_idle, clk, rst_n, !in_msg_r, pos_r == '0)

endmodule
